FILE: rtl/core/ppi_pkg.sv
// Shared widths, types and codes for the plane-plane intersection block.
package ppi_pkg;

  localparam int NORM_W         = 16;
  localparam int OFS_W          = 32;
  localparam int DIR_W          = 31;
  localparam int DIR_FULL_W     = 32;
  localparam int PT_W           = 32;
  localparam int FRAC_SH        = 14;
  localparam int PROD_W         = 2 * NORM_W;
  localparam int MUL_W          = OFS_W + NORM_W;
  localparam int NUM1_W         = MUL_W + FRAC_SH;
  localparam int NUM2_W         = MUL_W;
  localparam int FIFO_DEPTH_DEF = 4;
  localparam int IN_TDATA_W     = 160;
  localparam int OUT_TDATA_W    = 192;
  localparam int OUT_TUSER_W    = 2;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic signed [DIR_FULL_W-1:0] dir_x;
    logic signed [DIR_FULL_W-1:0] dir_y;
    logic signed [DIR_FULL_W-1:0] dir_z;
    logic                         par;
    axis_e                        zero_ax;
    logic signed [NUM1_W-1:0]     num1;
    logic signed [DIR_FULL_W-1:0] den1;
    logic signed [OFS_W-1:0]      dp;
    logic signed [NORM_W-1:0]     pl_s;
    logic signed [NORM_W-1:0]     pl_t;
  } work_t;

endpackage

FILE: rtl/core/ppi_front.sv
// Front pipeline: cross product, axis choice and first numerator.
module ppi_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [ppi_pkg::IN_TDATA_W-1:0]   s_data_i,
  input  logic                             full_i,
  output logic                             push_o,
  output ppi_pkg::work_t                   work_o
);
  import ppi_pkg::*;

  logic en, acc;

  logic signed [NORM_W-1:0] a_in [3];
  logic signed [NORM_W-1:0] b_in [3];

  logic                     v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [NORM_W-1:0] a1_q [3], b1_q [3], a2_q [3], b2_q [3], a3_q [3], b3_q [3];
  logic signed [OFS_W-1:0]  d0_1_q, d1_1_q, d0_2_q, d1_2_q, d0_3_q, d1_3_q, d0_4_q, d1_4_q;
  logic signed [PROD_W-1:0] prod1_q [6];
  logic signed [DIR_FULL_W-1:0] dir2_q [3], dir3_q [3], dir4_q [3], dir5_q [3];
  logic                     par3_q, par4_q, par5_q;
  axis_e                    zero3_q, zero4_q, zero5_q;

  logic [DIR_FULL_W-1:0]    mag [3];
  axis_e                    zero_d;

  logic signed [NORM_W-1:0] a_t, b_t, a_s, b_s;
  logic [NORM_W-1:0]        ma_t, mb_t;
  logic signed [DIR_FULL_W-1:0] den_d;
  logic signed [NORM_W-1:0] a4_t_q, b4_t_q, pls4_q, plt4_q, pls5_q, plt5_q;
  logic signed [DIR_FULL_W-1:0] den4_q, den5_q;
  logic signed [OFS_W-1:0]  dp4_q, dp5_q;
  logic signed [MUL_W-1:0]  m0_q, m1_q, mdiff;

  // Pipeline moves unless the last stage holds an item the queue cannot take.
  assign en        = !(v5_q && full_i);
  assign s_ready_o = en;
  assign acc       = s_valid_i && en;
  assign push_o    = v5_q && !full_i;

  // Field unpacking, lowest field in the lowest bits.
  assign a_in[0] = s_data_i[15:0];
  assign a_in[1] = s_data_i[31:16];
  assign a_in[2] = s_data_i[47:32];
  assign b_in[0] = s_data_i[95:80];
  assign b_in[1] = s_data_i[111:96];
  assign b_in[2] = s_data_i[127:112];

  // Valid chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage 1: the six partial products of the cross product.
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod1_q[0] <= PROD_W'(a_in[1]) * PROD_W'(b_in[2]);
      prod1_q[1] <= PROD_W'(a_in[2]) * PROD_W'(b_in[1]);
      prod1_q[2] <= PROD_W'(a_in[2]) * PROD_W'(b_in[0]);
      prod1_q[3] <= PROD_W'(a_in[0]) * PROD_W'(b_in[2]);
      prod1_q[4] <= PROD_W'(a_in[0]) * PROD_W'(b_in[1]);
      prod1_q[5] <= PROD_W'(a_in[1]) * PROD_W'(b_in[0]);
      a1_q   <= a_in;
      b1_q   <= b_in;
      d0_1_q <= s_data_i[79:48];
      d1_1_q <= s_data_i[159:128];
    end
  end

  // Stage 2: direction components.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dir2_q[0] <= prod1_q[0] - prod1_q[1];
      dir2_q[1] <= prod1_q[2] - prod1_q[3];
      dir2_q[2] <= prod1_q[4] - prod1_q[5];
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      d0_2_q <= d0_1_q;
      d1_2_q <= d1_1_q;
    end
  end

  // Stage 3: pick the axis of largest magnitude, y before z before x on ties.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = dir2_q[k][DIR_FULL_W-1] ? DIR_FULL_W'(-dir2_q[k]) : DIR_FULL_W'(dir2_q[k]);
    end
    if (mag[1] >= mag[2] && mag[1] >= mag[0]) begin
      zero_d = AXIS_Y;
    end else if (mag[2] >= mag[0]) begin
      zero_d = AXIS_Z;
    end else begin
      zero_d = AXIS_X;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      par3_q  <= (dir2_q[0] == '0) && (dir2_q[1] == '0) && (dir2_q[2] == '0);
      zero3_q <= zero_d;
      dir3_q  <= dir2_q;
      a3_q    <= a2_q;
      b3_q    <= b2_q;
      d0_3_q  <= d0_2_q;
      d1_3_q  <= d1_2_q;
    end
  end

  // Stage 4: route the normals of the solved and third axes, choose a plane.
  always_comb begin
    case (zero3_q)
      AXIS_Y: begin
        a_s = a3_q[0]; b_s = b3_q[0]; a_t = a3_q[2]; b_t = b3_q[2]; den_d = dir3_q[1];
      end
      AXIS_Z: begin
        a_s = a3_q[1]; b_s = b3_q[1]; a_t = a3_q[0]; b_t = b3_q[0]; den_d = dir3_q[2];
      end
      default: begin
        a_s = a3_q[2]; b_s = b3_q[2]; a_t = a3_q[1]; b_t = b3_q[1]; den_d = dir3_q[0];
      end
    endcase
    ma_t = a_t[NORM_W-1] ? NORM_W'(-a_t) : NORM_W'(a_t);
    mb_t = b_t[NORM_W-1] ? NORM_W'(-b_t) : NORM_W'(b_t);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_t_q <= a_t;
      b4_t_q <= b_t;
      den4_q <= den_d;
      d0_4_q <= d0_3_q;
      d1_4_q <= d1_3_q;
      if (ma_t > mb_t) begin
        pls4_q <= a_s;
        plt4_q <= a_t;
        dp4_q  <= d0_3_q;
      end else begin
        pls4_q <= b_s;
        plt4_q <= b_t;
        dp4_q  <= d1_3_q;
      end
      dir4_q  <= dir3_q;
      par4_q  <= par3_q;
      zero4_q <= zero3_q;
    end
  end

  // Stage 5: offset-times-normal products of the 2x2 solve.
  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_q    <= MUL_W'(d1_4_q) * MUL_W'(a4_t_q);
      m1_q    <= MUL_W'(d0_4_q) * MUL_W'(b4_t_q);
      den5_q  <= den4_q;
      dp5_q   <= dp4_q;
      pls5_q  <= pls4_q;
      plt5_q  <= plt4_q;
      dir5_q  <= dir4_q;
      par5_q  <= par4_q;
      zero5_q <= zero4_q;
    end
  end

  // Item for the queue.
  assign mdiff = m0_q - m1_q;

  always_comb begin
    work_o.dir_x   = dir5_q[0];
    work_o.dir_y   = dir5_q[1];
    work_o.dir_z   = dir5_q[2];
    work_o.par     = par5_q;
    work_o.zero_ax = zero5_q;
    work_o.num1    = {mdiff, {FRAC_SH{1'b0}}};
    work_o.den1    = den5_q;
    work_o.dp      = dp5_q;
    work_o.pl_s    = pls5_q;
    work_o.pl_t    = plt5_q;
  end

endmodule

FILE: rtl/core/ppi_fifo.sv
// Small register queue between the front and the back.
module ppi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ppi_div.sv
// Pipelined restoring divider, truncating toward zero, with 32-bit clamping.
module ppi_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [NUM_W-1:0]        num_i,
  input  logic signed [DEN_W-1:0]        den_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           valid_o,
  output logic signed [ppi_pkg::PT_W-1:0] quot_o,
  output logic                           sat_o,
  output logic [SIDE_W-1:0]              side_o
);
  import ppi_pkg::*;

  localparam int QW    = PT_W;
  localparam int HI_W  = NUM_W - QW;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic              va_q, nega_q, dza_q;
  logic [NUM_W-1:0]  nmaga_q;
  logic [DEN_W-1:0]  dmaga_q;
  logic [SIDE_W-1:0] sidea_q;
  logic [CMP_W-1:0]  hi_ext, dm_ext;

  logic              v_q    [QW+1];
  logic [DEN_W-1:0]  rem_q  [QW+1];
  logic [QW-1:0]     lo_q   [QW+1];
  logic [QW-1:0]     quo_q  [QW+1];
  logic [DEN_W-1:0]  dmag_q [QW+1];
  logic              neg_q  [QW+1];
  logic              ovf_q  [QW+1];
  logic              dz_q   [QW+1];
  logic [SIDE_W-1:0] side_q [QW+1];

  logic              vo_q, sat_q;
  logic signed [QW-1:0] quot_q, quot_d;
  logic              sat_d;
  logic [SIDE_W-1:0] sideo_q;
  logic [QW-1:0]     qf;

  // Stage A: magnitudes and signs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmaga_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      dmaga_q <= den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
      nega_q  <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      dza_q   <= (den_i == '0);
      sidea_q <= side_i;
    end
  end

  // Stage B: quotients of 2^32 or more are caught here; the rest seeds the remainder.
  assign hi_ext = CMP_W'(nmaga_q[NUM_W-1:QW]);
  assign dm_ext = CMP_W'(dmaga_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= hi_ext[DEN_W-1:0];
      lo_q[0]   <= nmaga_q[QW-1:0];
      quo_q[0]  <= '0;
      dmag_q[0] <= dmaga_q;
      neg_q[0]  <= nega_q;
      ovf_q[0]  <= (hi_ext >= dm_ext);
      dz_q[0]   <= dza_q;
      side_q[0] <= sidea_q;
    end
  end

  // One quotient bit per stage.
  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DEN_W:0] trial, diff;
    logic           ge;

    assign trial = {rem_q[k-1], lo_q[k-1][QW-1]};
    assign diff  = trial - {1'b0, dmag_q[k-1]};
    assign ge    = (trial >= {1'b0, dmag_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_q[k]   <= {lo_q[k-1][QW-2:0], 1'b0};
        quo_q[k]  <= {quo_q[k-1][QW-2:0], ge};
        dmag_q[k] <= dmag_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
        dz_q[k]   <= dz_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stage C: sign and clamp to the 32-bit range; a zero divisor gives zero.
  assign qf = quo_q[QW];

  always_comb begin
    sat_d  = 1'b0;
    quot_d = qf;
    if (dz_q[QW]) begin
      quot_d = '0;
    end else if (ovf_q[QW]) begin
      sat_d  = 1'b1;
      quot_d = neg_q[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else if (!neg_q[QW]) begin
      if (qf[QW-1]) begin
        sat_d  = 1'b1;
        quot_d = {1'b0, {(QW-1){1'b1}}};
      end
    end else begin
      if (qf[QW-1] && (qf[QW-2:0] != '0)) begin
        sat_d  = 1'b1;
        quot_d = {1'b1, {(QW-1){1'b0}}};
      end else begin
        quot_d = -qf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q  <= quot_d;
      sat_q   <= sat_d;
      sideo_q <= side_q[QW];
    end
  end

  assign valid_o = vo_q;
  assign quot_o  = quot_q;
  assign sat_o   = sat_q;
  assign side_o  = sideo_q;

endmodule

FILE: rtl/core/ppi_back.sv
// Back pipeline: both divisions, back substitution and the output register.
module ppi_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               empty_i,
  input  ppi_pkg::work_t                     work_i,
  output logic                               pop_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [ppi_pkg::OUT_TDATA_W-1:0]    m_data_o,
  output logic [ppi_pkg::OUT_TUSER_W-1:0]    m_user_o
);
  import ppi_pkg::*;

  typedef struct packed {
    logic signed [DIR_FULL_W-1:0] dir_x;
    logic signed [DIR_FULL_W-1:0] dir_y;
    logic signed [DIR_FULL_W-1:0] dir_z;
    logic                         par;
    axis_e                        zero_ax;
    logic signed [OFS_W-1:0]      dp;
    logic signed [NORM_W-1:0]     pl_s;
    logic signed [NORM_W-1:0]     pl_t;
  } side1_t;

  typedef struct packed {
    logic signed [DIR_FULL_W-1:0] dir_x;
    logic signed [DIR_FULL_W-1:0] dir_y;
    logic signed [DIR_FULL_W-1:0] dir_z;
    logic                         par;
    axis_e                        zero_ax;
    logic signed [PT_W-1:0]       p_s;
    logic                         sat1;
  } side2_t;

  logic en;
  side1_t side1_in, side1_out;
  side2_t side2_m_q, side2_n_q, side2_out;
  logic   v1_out, sat1_out, v2_out, sat2_out;
  logic signed [PT_W-1:0] q1_out, q2_out;

  logic                         vm_q, vn_q;
  logic signed [MUL_W-1:0]      prod_m_q;
  logic signed [OFS_W-1:0]      dp_m_q;
  logic signed [NORM_W-1:0]     plt_m_q, plt_n_q;
  logic signed [OFS_W+FRAC_SH-1:0] dp_sh;
  logic signed [NUM2_W-1:0]     num2_n_q;

  logic                   mv_q, par_q, sat_q;
  logic signed [DIR_FULL_W-1:0] dx_q, dy_q, dz_q;
  logic signed [PT_W-1:0] px_q, py_q, pz_q;
  logic signed [PT_W-1:0] px_d, py_d, pz_d;

  // The whole back advances whenever the output register is free or being taken.
  assign en    = !mv_q || m_ready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    side1_in.dir_x   = work_i.dir_x;
    side1_in.dir_y   = work_i.dir_y;
    side1_in.dir_z   = work_i.dir_z;
    side1_in.par     = work_i.par;
    side1_in.zero_ax = work_i.zero_ax;
    side1_in.dp      = work_i.dp;
    side1_in.pl_s    = work_i.pl_s;
    side1_in.pl_t    = work_i.pl_t;
  end

  // Solved coordinate from the 2x2 system.
  ppi_div #(
    .NUM_W  (NUM1_W),
    .DEN_W  (DIR_FULL_W),
    .SIDE_W ($bits(side1_t))
  ) u_div_solve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pop_o),
    .num_i   (work_i.num1),
    .den_i   (work_i.den1),
    .side_i  (side1_in),
    .valid_o (v1_out),
    .quot_o  (q1_out),
    .sat_o   (sat1_out),
    .side_o  (side1_out)
  );

  // Back substitution: product of the clamped coordinate and the plane normal.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vn_q <= 1'b0;
    end else if (en) begin
      vm_q <= v1_out;
      vn_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_m_q          <= MUL_W'(q1_out) * MUL_W'(side1_out.pl_s);
      dp_m_q            <= side1_out.dp;
      plt_m_q           <= side1_out.pl_t;
      side2_m_q.dir_x   <= side1_out.dir_x;
      side2_m_q.dir_y   <= side1_out.dir_y;
      side2_m_q.dir_z   <= side1_out.dir_z;
      side2_m_q.par     <= side1_out.par;
      side2_m_q.zero_ax <= side1_out.zero_ax;
      side2_m_q.p_s     <= q1_out;
      side2_m_q.sat1    <= sat1_out;
    end
  end

  // Numerator of the third coordinate.
  assign dp_sh = {dp_m_q, {FRAC_SH{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en) begin
      num2_n_q  <= NUM2_W'(dp_sh) - prod_m_q;
      plt_n_q   <= plt_m_q;
      side2_n_q <= side2_m_q;
    end
  end

  ppi_div #(
    .NUM_W  (NUM2_W),
    .DEN_W  (NORM_W),
    .SIDE_W ($bits(side2_t))
  ) u_div_third (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vn_q),
    .num_i   (num2_n_q),
    .den_i   (plt_n_q),
    .side_i  (side2_n_q),
    .valid_o (v2_out),
    .quot_o  (q2_out),
    .sat_o   (sat2_out),
    .side_o  (side2_out)
  );

  // Place the coordinates on their axes; parallel planes give the origin.
  always_comb begin
    px_d = '0;
    py_d = '0;
    pz_d = '0;
    if (!side2_out.par) begin
      case (side2_out.zero_ax)
        AXIS_Y: begin
          px_d = side2_out.p_s;
          pz_d = q2_out;
        end
        AXIS_Z: begin
          py_d = side2_out.p_s;
          px_d = q2_out;
        end
        default: begin
          pz_d = side2_out.p_s;
          py_d = q2_out;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (en) begin
      mv_q <= v2_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= side2_out.dir_x;
      dy_q  <= side2_out.dir_y;
      dz_q  <= side2_out.dir_z;
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
      par_q <= side2_out.par;
      sat_q <= !side2_out.par && (side2_out.sat1 || sat2_out);
    end
  end

  assign m_valid_o = mv_q;
  assign m_data_o  = {3'b000, pz_q, py_q, px_q,
                      dz_q[DIR_W-1:0], dy_q[DIR_W-1:0], dx_q[DIR_W-1:0]};
  assign m_user_o  = {sat_q, par_q};

endmodule

FILE: rtl/core/plane_plane_intersection.sv
// Throughput: one item per cycle without stalls; two divider pipelines set the latency.
// A four-entry queue separates the 5-stage front from the back so either can stall.
// Reset (rst_ni low, asynchronous) empties the queue and clears all valid bits.
// Stalls on m_tready hold the whole back; the front fills the queue before it stalls.
// Top level of the plane-plane intersection block.
module plane_plane_intersection #(
  parameter int FIFO_DEPTH = ppi_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // first_normal_x, first_normal_y, first_normal_z, first_offset,
  // second_normal_x, second_normal_y, second_normal_z, second_offset
  input  logic [ppi_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // direction_x, direction_y, direction_z, point_x, point_y, point_z, zero pad
  output logic [ppi_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // parallel_flag, saturated_flag
  output logic [ppi_pkg::OUT_TUSER_W-1:0]  m_tuser
);
  import ppi_pkg::*;

  logic  push, full, pop, empty;
  work_t work_in, work_out;

  ppi_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_tvalid),
    .s_ready_o (s_tready),
    .s_data_i  (s_tdata),
    .full_i    (full),
    .push_o    (push),
    .work_o    (work_in)
  );

  ppi_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (work_out),
    .empty_o (empty)
  );

  ppi_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .work_i    (work_out),
    .pop_o     (pop),
    .m_valid_o (m_tvalid),
    .m_ready_i (m_tready),
    .m_data_o  (m_tdata),
    .m_user_o  (m_tuser)
  );

endmodule

FILE: tb/plane_plane_intersection_checker.sv
// Checker for the plane-plane intersection block: it predicts each line and compares results.
module plane_plane_intersection_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [ppi_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [ppi_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic [ppi_pkg::OUT_TUSER_W-1:0] m_tuser_i,
  output int                              fail_count_o,
  output int                              pending_count_o,
  output int                              line_count_o,
  output int                              parallel_count_o,
  output int                              clamped_count_o
);
  import ppi_pkg::*;

  typedef struct packed {
    logic [DIR_W-1:0] dir_x;
    logic [DIR_W-1:0] dir_y;
    logic [DIR_W-1:0] dir_z;
    logic [PT_W-1:0]  pt_x;
    logic [PT_W-1:0]  pt_y;
    logic [PT_W-1:0]  pt_z;
    logic             parallel;
    logic             clamped;
  } line_t;

  line_t pending_lines[$];

  // Truncating quotient clamped to 32 bits; a zero divisor gives zero.
  function automatic longint clamp_div(longint num, longint den, inout bit clamped);
    longint q;
    if (den == 0) return 0;
    q = num / den;
    if (q > 64'sd2147483647) begin
      clamped = 1'b1;
      return 64'sd2147483647;
    end
    if (q < -64'sd2147483648) begin
      clamped = 1'b1;
      return -64'sd2147483648;
    end
    return q;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Line of intersection of the two planes in one input item.
  function automatic line_t intersect_planes(logic [IN_TDATA_W-1:0] d);
    longint n0[3], n1[3], dir[3], pt[3], pl[3];
    longint off0, off1, dp;
    int     zr, sv, th;
    bit     clamped;
    line_t  r;
    n0[0] = longint'($signed(d[15:0]));
    n0[1] = longint'($signed(d[31:16]));
    n0[2] = longint'($signed(d[47:32]));
    off0  = longint'($signed(d[79:48]));
    n1[0] = longint'($signed(d[95:80]));
    n1[1] = longint'($signed(d[111:96]));
    n1[2] = longint'($signed(d[127:112]));
    off1  = longint'($signed(d[159:128]));
    clamped = 1'b0;
    dir[0] = n0[1] * n1[2] - n0[2] * n1[1];
    dir[1] = n0[2] * n1[0] - n0[0] * n1[2];
    dir[2] = n0[0] * n1[1] - n0[1] * n1[0];
    pt[0] = 0;
    pt[1] = 0;
    pt[2] = 0;
    r.parallel = (dir[0] == 0) && (dir[1] == 0) && (dir[2] == 0);
    if (!r.parallel) begin
      // Largest direction component picks the axis held at zero; ties favour y, then z.
      if (mag(dir[1]) >= mag(dir[2]) && mag(dir[1]) >= mag(dir[0])) begin
        zr = 1; sv = 0; th = 2;
      end else if (mag(dir[2]) >= mag(dir[0])) begin
        zr = 2; sv = 1; th = 0;
      end else begin
        zr = 0; sv = 2; th = 1;
      end
      pt[sv] = clamp_div((off1 * n0[th] - off0 * n1[th]) * 16384, dir[zr], clamped);
      // Back substitution uses the plane with the strictly larger normal; the second on ties.
      if (mag(n0[th]) > mag(n1[th])) begin
        pl = n0; dp = off0;
      end else begin
        pl = n1; dp = off1;
      end
      pt[th] = clamp_div(dp * 16384 - pt[sv] * pl[sv], pl[th], clamped);
    end
    r.dir_x   = dir[0][DIR_W-1:0];
    r.dir_y   = dir[1][DIR_W-1:0];
    r.dir_z   = dir[2][DIR_W-1:0];
    r.pt_x    = pt[0][PT_W-1:0];
    r.pt_y    = pt[1][PT_W-1:0];
    r.pt_z    = pt[2][PT_W-1:0];
    r.clamped = clamped;
    return r;
  endfunction

  function automatic int field_ok(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, expv, actv);
      return 0;
    end
    return 1;
  endfunction

  assign pending_count_o = pending_lines.size();

  // Record expected lines on input items and compare on output items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    line_t e;
    line_t a;
    int    ok;
    if (!rst_ni) begin
      fail_count_o     <= 0;
      line_count_o     <= 0;
      parallel_count_o <= 0;
      clamped_count_o  <= 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        pending_lines.push_back(intersect_planes(s_tdata_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        a.dir_x    = m_tdata_i[30:0];
        a.dir_y    = m_tdata_i[61:31];
        a.dir_z    = m_tdata_i[92:62];
        a.pt_x     = m_tdata_i[124:93];
        a.pt_y     = m_tdata_i[156:125];
        a.pt_z     = m_tdata_i[188:157];
        a.parallel = m_tuser_i[0];
        a.clamped  = m_tuser_i[1];
        line_count_o <= line_count_o + 1;
        if (pending_lines.size() == 0) begin
          $error("output item with no expected line waiting");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e  = pending_lines.pop_front();
          ok = field_ok("direction_x", 32'(e.dir_x), 32'(a.dir_x))
             & field_ok("direction_y", 32'(e.dir_y), 32'(a.dir_y))
             & field_ok("direction_z", 32'(e.dir_z), 32'(a.dir_z))
             & field_ok("point_x", e.pt_x, a.pt_x)
             & field_ok("point_y", e.pt_y, a.pt_y)
             & field_ok("point_z", e.pt_z, a.pt_z)
             & field_ok("parallel_flag", 32'(e.parallel), 32'(a.parallel))
             & field_ok("saturated_flag", 32'(e.clamped), 32'(a.clamped));
          if (!ok) fail_count_o <= fail_count_o + 1;
          if (e.parallel) parallel_count_o <= parallel_count_o + 1;
          if (e.clamped) clamped_count_o <= clamped_count_o + 1;
        end
      end
    end
  end

endmodule

FILE: tb/plane_plane_intersection_tb.sv
// Testbench top for the plane-plane intersection block: stimulus, stalls and verdict.
module plane_plane_intersection_tb;
  import ppi_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 120;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  int                     fail_count;
  int                     pending_count;
  int                     line_count;
  int                     parallel_count;
  int                     clamped_count;
  int                     stall_mode;
  int                     sent_count;

  plane_plane_intersection u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  plane_plane_intersection_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tuser_i       (m_tuser),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count),
    .line_count_o    (line_count),
    .parallel_count_o(parallel_count),
    .clamped_count_o (clamped_count)
  );

  // Clock with a period of four units.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The receiver switches between free flow, random stalls and a fixed pattern.
  initial begin
    m_tready   = 1'b0;
    stall_mode = 0;
  end
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      2: m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= ~m_tready;
    endcase
  end

  function automatic logic [IN_TDATA_W-1:0] pack_planes(
    logic [15:0] ax, logic [15:0] ay, logic [15:0] az, logic [31:0] ad,
    logic [15:0] bx, logic [15:0] by, logic [15:0] bz, logic [31:0] bd);
    return {bd, bz, by, bx, ad, az, ay, ax};
  endfunction

  // Normal component: mostly in the Q1.14 range, sometimes any 16-bit value.
  function automatic logic [15:0] rand_normal();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [31:0] rand_offset();
    case ($urandom_range(0, 3))
      0: return 32'($urandom);
      1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      2: return 32'($signed($urandom_range(0, 2 ** 13)) - 2 ** 12);
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Random item: general planes, nearly parallel planes, or exactly parallel ones.
  function automatic logic [IN_TDATA_W-1:0] rand_planes();
    logic [15:0] ax, ay, az, bx, by, bz;
    ax = rand_normal();
    ay = rand_normal();
    az = rand_normal();
    case ($urandom_range(0, 9))
      0: begin
        bx = ax; by = ay; bz = az;
      end
      1, 2: begin
        bx = ax + 16'($signed($urandom_range(0, 4)) - 2);
        by = ay + 16'($signed($urandom_range(0, 4)) - 2);
        bz = az + 16'($signed($urandom_range(0, 4)) - 2);
      end
      default: begin
        bx = rand_normal(); by = rand_normal(); bz = rand_normal();
      end
    endcase
    return pack_planes(ax, ay, az, rand_offset(), bx, by, bz, rand_offset());
  endfunction

  // Ready as seen just before each rising edge.
  logic s_tready_q;
  always @(negedge clk_i) s_tready_q = s_tready;

  // Present one item and hold it until it is accepted.
  task automatic send_item(logic [IN_TDATA_W-1:0] planes);
    bit taken;
    s_tvalid <= 1'b1;
    s_tdata  <= planes;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = s_tready_q;
    end
    sent_count++;
  endtask

  task automatic pause(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin
    logic [IN_TDATA_W-1:0] directed[$];
    int burst;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    sent_count = 0;
    rst_ni     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Axis-aligned planes, extreme normals and offsets.
    directed.push_back(pack_planes(16'sd16384, 0, 0, 32'h0001_0000,
                                   0, 16'sd16384, 0, 32'hffff_0000));
    directed.push_back(pack_planes(0, 16'sd16384, 0, 32'h7fff_ffff,
                                   0, 0, 16'sd16384, 32'h8000_0000));
    directed.push_back(pack_planes(-16'sd16384, -16'sd16384, 16'sd16384, 32'h8000_0000,
                                   16'sd16384, -16'sd16384, -16'sd16384, 32'h7fff_ffff));
    // Parallel planes, including identical and opposite normals.
    directed.push_back(pack_planes(16'sd100, 16'sd200, 16'sd300, 32'h0000_1000,
                                   16'sd100, 16'sd200, 16'sd300, 32'h0000_2000));
    directed.push_back(pack_planes(16'sd16384, 0, 0, 32'h1234_5678,
                                   -16'sd16384, 0, 0, 32'h8765_4321));
    directed.push_back(pack_planes(0, 0, 0, 32'h7fff_ffff, 16'sd5, 16'sd6, 16'sd7, 0));
    // Ties between direction magnitudes: x with y, y with z, x with z.
    directed.push_back(pack_planes(16'sd1, 16'sd1, 0, 32'h0004_0000,
                                   0, 0, 16'sd1, 32'hfffc_0000));
    directed.push_back(pack_planes(16'sd1, 0, 0, 32'h0002_0000,
                                   0, 16'sd1, 16'sd1, 32'h0003_0000));
    directed.push_back(pack_planes(0, 16'sd1, 0, 32'h0005_0000,
                                   16'sd1, 0, 16'sd1, 32'hfffb_0000));
    directed.push_back(pack_planes(16'sd16384, 16'sd16384, 16'sd16384, 32'h0001_0000,
                                   16'sd16384, -16'sd16384, 16'sd16384, 32'h0002_0000));
    // Equal normal magnitudes on the back-substitution axis.
    directed.push_back(pack_planes(16'sd3000, 0, 16'sd5000, 32'h0010_0000,
                                   0, 16'sd3000, -16'sd5000, 32'hfff0_0000));
    // Tiny direction with huge offsets forces saturation.
    directed.push_back(pack_planes(16'sd16384, 16'sd1, 0, 32'h7fff_ffff,
                                   16'sd16384, 0, 0, 32'h8000_0000));
    directed.push_back(pack_planes(16'sd1, 16'sd16384, 16'sd16383, 32'h8000_0000,
                                   16'sd1, 16'sd16383, 16'sd16384, 32'h7fff_ffff));
    // Normals outside the Q1.14 range make the direction wrap.
    directed.push_back(pack_planes(16'h8000, 16'h7fff, 16'h8000, 32'hffff_ffff,
                                   16'h7fff, 16'h8000, 16'h7fff, 32'h0000_0001));
    directed.push_back(pack_planes(16'hffff, 16'h8000, 16'h7fff, 32'h0,
                                   16'h8000, 16'h8000, 16'h0001, 32'hffff_ffff));
    directed.push_back(pack_planes(0, 0, 0, 0, 0, 0, 0, 0));
    foreach (directed[i]) send_item(directed[i]);

    // Random bursts, with at least one full drain half way through.
    while (sent_count < directed.size() + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_item(rand_planes());
      if (sent_count >= directed.size() + RANDOM_ITEMS / 2 &&
          sent_count < directed.size() + RANDOM_ITEMS / 2 + 41) begin
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_count != 0);
      end else if ($urandom_range(0, 2) != 0) begin
        pause($urandom_range(1, 12));
      end
    end
    s_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d plane pairs; %0d lines checked, %0d parallel and %0d clamped.",
             sent_count, line_count, parallel_count, clamped_count);
    $display("Stimulus spanned axis ties, wrapped normals and a full drain mid-run.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard limit on the length of the run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: plane_plane_intersection.f
rtl/core/ppi_pkg.sv
rtl/core/ppi_front.sv
rtl/core/ppi_fifo.sv
rtl/core/ppi_div.sv
rtl/core/ppi_back.sv
rtl/core/plane_plane_intersection.sv
tb/plane_plane_intersection_checker.sv
tb/plane_plane_intersection_tb.sv
